[rtl/bga_pkg.sv]
// Shared types, constants and helpers of the grid automaton step block.
`default_nettype none

package bga_pkg;

  localparam int unsigned RowWidth   = 32;
  localparam int unsigned MaxColumns = 32;
  localparam int unsigned ColsWidth  = 6;
  localparam int unsigned LimitWidth = 4;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 6;

  localparam logic [LimitWidth-1:0] BirthReset   = LimitWidth'(4);
  localparam logic [LimitWidth-1:0] DeathReset   = LimitWidth'(5);
  localparam logic [ColsWidth-1:0]  ColumnsReset = ColsWidth'(32);

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgBirthLimit   = 2'd0,
    CfgDeathLimit   = 2'd1,
    CfgColumnsInUse = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [RowWidth-1:0] row_cells;
    logic                last_row;
  } in_t;

  typedef struct packed {
    logic [RowWidth-1:0] new_row_cells;
    logic                grid_done;
  } out_t;

  typedef struct packed {
    logic first;
    logic second;
  } push_t;

  function automatic logic [RowWidth-1:0] width_mask(input logic [ColsWidth-1:0] cols);
    logic [ColsWidth:0]  w;
    logic [RowWidth-1:0] m;
    w = ({1'b0, cols} > (ColsWidth+1)'(MaxColumns)) ? (ColsWidth+1)'(MaxColumns)
                                                     : {1'b0, cols};
    for (int c = 0; c < RowWidth; c++) begin
      m[c] = ((ColsWidth+1)'(c) < w);
    end
    return m;
  endfunction

endpackage

`default_nettype wire

[rtl/bga_gen.sv]
// Next-generation row from three neighbouring rows.
`default_nettype none

module bga_gen (
  input  logic [bga_pkg::RowWidth-1:0]   above_i,
  input  logic [bga_pkg::RowWidth-1:0]   here_i,
  input  logic [bga_pkg::RowWidth-1:0]   below_i,
  input  logic [bga_pkg::ColsWidth-1:0]  cols_i,
  input  logic [bga_pkg::LimitWidth-1:0] birth_i,
  input  logic [bga_pkg::LimitWidth-1:0] death_i,
  output logic [bga_pkg::RowWidth-1:0]   row_o
);
  import bga_pkg::*;

  logic [RowWidth-1:0] mask;
  logic [RowWidth+1:0] a_pad;
  logic [RowWidth+1:0] h_pad;
  logic [RowWidth+1:0] b_pad;

  assign mask  = width_mask(cols_i);
  assign a_pad = {1'b0, above_i & mask, 1'b0};
  assign h_pad = {1'b0, here_i & mask, 1'b0};
  assign b_pad = {1'b0, below_i & mask, 1'b0};

  always_comb begin
    logic [3:0] cnt;
    for (int c = 0; c < RowWidth; c++) begin
      cnt = 4'(a_pad[c]) + 4'(a_pad[c+1]) + 4'(a_pad[c+2])
          + 4'(h_pad[c]) + 4'(h_pad[c+2])
          + 4'(b_pad[c]) + 4'(b_pad[c+1]) + 4'(b_pad[c+2]);
      row_o[c] = mask[c] & (h_pad[c+1] ? (cnt >= death_i) : (cnt >= birth_i));
    end
  end

endmodule

`default_nettype wire

[rtl/bga_outq.sv]
// Result queue: up to two words written and one read per cycle.
`default_nettype none

module bga_outq (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  bga_pkg::push_t push_i,
  input  bga_pkg::out_t  first_i,
  input  bga_pkg::out_t  second_i,
  input  logic           pop_i,
  output logic           valid_o,
  output bga_pkg::out_t  data_o,
  output logic [2:0]     free_o
);
  import bga_pkg::*;

  localparam int unsigned Depth = 4;

  out_t       mem_q [Depth];
  logic [1:0] wr_q, wr_d;
  logic [1:0] rd_q, rd_d;
  logic [2:0] cnt_q, cnt_d;
  logic [1:0] n_push;
  logic       do_pop;

  assign n_push  = 2'(push_i.first) + 2'(push_i.second);
  assign valid_o = (cnt_q != 3'd0);
  assign data_o  = mem_q[rd_q];
  assign free_o  = 3'(Depth) - cnt_q;
  assign do_pop  = pop_i & valid_o;

  assign wr_d  = wr_q + n_push;
  assign rd_d  = rd_q + 2'(do_pop);
  assign cnt_d = cnt_q + 3'(n_push) - 3'(do_pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.first) begin
      mem_q[wr_q] <= first_i;
      if (push_i.second) begin
        mem_q[wr_q + 2'd1] <= second_i;
      end
    end else if (push_i.second) begin
      mem_q[wr_q] <= second_i;
    end
  end

endmodule

`default_nettype wire

[rtl/binary_grid_automaton_step_top.sv]
// Top level of the grid automaton step block.
`default_nettype none

// Unless stalled, one row word enters per cycle, registered with the two rows
// held before it; two row generators then produce the result for the held row
// and, on the grid's last row, the result for that row too, and both go into a
// four-word result queue. A word yields one result for the held row, plus one
// for itself when it is the grid's last row; a grid's first row yields none
// unless it is also the last.
// Rows are taken every cycle while the queue keeps room; a grid's last row
// pushes one extra word. Rows pass the stage registers, then the result queue.
module binary_grid_automaton_step_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bga_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bga_pkg::out_t                   out_data_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bga_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [bga_pkg::CfgDataWidth-1:0] cfg_data_i
);
  import bga_pkg::*;

  logic [LimitWidth-1:0] birth_q, death_q;
  logic [ColsWidth-1:0]  cols_q;

  logic [RowWidth-1:0] upper_q, middle_q;
  logic                holding_q;

  logic                st_valid_q;
  logic [RowWidth-1:0] st_above_q, st_here_q, st_in_q;
  logic                st_hold_q, st_last_q;

  logic                accept, st_adv;
  logic [1:0]          st_n;
  logic [2:0]          q_free;
  logic [RowWidth-1:0] res0, res1, above1;
  push_t               push;
  out_t                first_w, second_w;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      birth_q <= BirthReset;
      death_q <= DeathReset;
      cols_q  <= ColumnsReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CfgBirthLimit:   birth_q <= cfg_data_i[LimitWidth-1:0];
        CfgDeathLimit:   death_q <= cfg_data_i[LimitWidth-1:0];
        CfgColumnsInUse: cols_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign st_n       = 2'(st_hold_q) + 2'(st_last_q);
  assign st_adv     = st_valid_q && (q_free >= 3'(st_n));
  assign in_stall_o = st_valid_q && !st_adv;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upper_q    <= '0;
      middle_q   <= '0;
      holding_q  <= 1'b0;
      st_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        st_valid_q <= 1'b1;
        if (in_data_i.last_row) begin
          upper_q   <= '0;
          middle_q  <= '0;
          holding_q <= 1'b0;
        end else begin
          upper_q   <= holding_q ? middle_q : '0;
          middle_q  <= in_data_i.row_cells;
          holding_q <= 1'b1;
        end
      end else if (st_adv) begin
        st_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_above_q <= upper_q;
      st_here_q  <= middle_q;
      st_in_q    <= in_data_i.row_cells;
      st_hold_q  <= holding_q;
      st_last_q  <= in_data_i.last_row;
    end
  end

  assign above1 = st_hold_q ? st_here_q : '0;

  bga_gen u_gen_held (
    .above_i (st_above_q),
    .here_i  (st_here_q),
    .below_i (st_in_q),
    .cols_i  (cols_q),
    .birth_i (birth_q),
    .death_i (death_q),
    .row_o   (res0)
  );

  bga_gen u_gen_last (
    .above_i (above1),
    .here_i  (st_in_q),
    .below_i ('0),
    .cols_i  (cols_q),
    .birth_i (birth_q),
    .death_i (death_q),
    .row_o   (res1)
  );

  assign push.first  = st_adv & st_hold_q;
  assign push.second = st_adv & st_last_q;

  assign first_w.new_row_cells  = res0;
  assign first_w.grid_done      = 1'b0;
  assign second_w.new_row_cells = res1;
  assign second_w.grid_done     = 1'b1;

  bga_outq u_outq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .first_i  (first_w),
    .second_i (second_w),
    .pop_i    (!out_stall_i),
    .valid_o  (out_valid_o),
    .data_o   (out_data_o),
    .free_o   (q_free)
  );

endmodule

`default_nettype wire
